### rtl/ccf_pkg.sv
// Package for the complementary crossover FIR unit: field widths, codes,
// reset values, the sequencer state type and the MAC control struct.
// No dependencies.
package ccf_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int COEF_WIDTH   = 24;
   localparam int DIFF_WIDTH   = 25;
   localparam int FRAC_SHIFT   = 22;
   localparam int TAP_CFG_WIDTH  = 10;
   localparam int CHAN_CFG_WIDTH = 4;
   localparam int CHAN_WIDTH     = 3;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_PROCESS = 1'b1;

   localparam logic CSR_TAP_COUNT     = 1'b0;
   localparam logic CSR_CHANNEL_COUNT = 1'b1;

   localparam logic [TAP_CFG_WIDTH-1:0]  TAP_COUNT_RESET     = 10'd129;
   localparam logic [CHAN_CFG_WIDTH-1:0] CHANNEL_COUNT_RESET = 4'd1;
   localparam logic [TAP_CFG_WIDTH-1:0]  MIN_TAPS            = 10'd33;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_WRITE = 7'b0000100,
      ST_MAC   = 7'b0001000,
      ST_DRAIN = 7'b0010000,
      ST_ROUND = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctrl_type;

endpackage

### rtl/ccf_mac.sv
// Shared multiply-accumulate unit: one registered product stage followed
// by a wide accumulator. Depends on ccf_pkg.
module ccf_mac
   import ccf_pkg::*;
#(
   parameter int ACC_WIDTH = 59
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mac_ctrl_type                 ctrl,
   input  logic signed [COEF_WIDTH-1:0] coef,
   input  logic signed [DIFF_WIDTH-1:0] diff,
   output logic signed [ACC_WIDTH-1:0]  acc,
   output logic                         busy
);

   localparam int PROD_WIDTH = COEF_WIDTH + DIFF_WIDTH;

   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic                         prod_vld_ff, prod_vld_in;
   logic signed [ACC_WIDTH-1:0]  acc_ff, acc_in;

   always_comb begin
      prod_in     = coef * diff;
      prod_vld_in = ctrl.valid;
      acc_in      = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_WIDTH'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         acc_ff      <= acc_in;
      end
      prod_ff <= prod_in;
   end

   assign acc  = acc_ff;
   assign busy = prod_vld_ff;

endmodule

### rtl/complementary_crossover_fir_unit.sv
// Complementary crossover FIR unit: one shared MAC walks all taps per sample pair.
// With taps = tap_count clamped to 33..MAX_TAPS, a producing pair walks all taps in ST_MAC
// through the one coefficient/history read port feeding the MAC, then passes ST_DRAIN,
// ST_ROUND and ST_OUT to raise rsp_tvalid, later if an older result waits on rsp_tready.
// New transactions are accepted only in ST_IDLE. Warm-up pairs pass ST_WRITE only, loads and
// ignored pairs stay in ST_IDLE. Reset first zeroes all MAX_TAPS * MAX_CHANNELS entries.
module complementary_crossover_fir_unit
   import ccf_pkg::*;
#(
   parameter int MAX_TAPS     = 513,
   parameter int MAX_CHANNELS = 8
) (
   input  logic         clock,
   input  logic         reset,
   // Configuration write port.
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [9:0]   csr_wdata,
   // Input stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata, low bit up: tap_index[9:0], tap_value[33:10], chan_index[36:34],
   // low_sample[60:37], high_sample[84:61], zero pad[87:85].
   input  logic [87:0]  req_tdata,
   // tuser: func (0 loads a coefficient, 1 processes a sample pair).
   input  logic         req_tuser,
   // Result stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata, low bit up: out_chan[2:0], out_sample[26:3], zero pad[31:27].
   output logic [31:0]  rsp_tdata
);

   // Storage and arithmetic widths follow from the two size parameters.
   localparam int HIST_DEPTH = MAX_TAPS * MAX_CHANNELS;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int TAP_AW     = $clog2(MAX_TAPS);
   localparam int TAP_CW     = $clog2(MAX_TAPS + 1);
   localparam int CH_CW      = $clog2(MAX_CHANNELS + 1);
   localparam int ACC_WIDTH  = COEF_WIDTH + DIFF_WIDTH + $clog2(MAX_TAPS);
   localparam int LP_WIDTH   = ACC_WIDTH - FRAC_SHIFT;
   localparam int SUM_WIDTH  = LP_WIDTH + 1;
   localparam logic signed [SUM_WIDTH-1:0] SAT_HI = SUM_WIDTH'(8388607);
   localparam logic signed [SUM_WIDTH-1:0] SAT_LO = SUM_WIDTH'(-8388608);
   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1 << (FRAC_SHIFT - 1));

   // Unpacked input fields.
   logic                           in_func;
   logic [TAP_CFG_WIDTH-1:0]       in_tap_index;
   logic signed [COEF_WIDTH-1:0]   in_tap_value;
   logic [CHAN_WIDTH-1:0]          in_chan_index;
   logic signed [SAMPLE_WIDTH-1:0] in_low_sample;
   logic signed [SAMPLE_WIDTH-1:0] in_high_sample;

   assign in_func        = req_tuser;
   assign in_tap_index   = req_tdata[9:0];
   assign in_tap_value   = req_tdata[33:10];
   assign in_chan_index  = req_tdata[36:34];
   assign in_low_sample  = req_tdata[60:37];
   assign in_high_sample = req_tdata[84:61];

   // Configuration registers.
   logic [TAP_CFG_WIDTH-1:0]  tap_count_ff;
   logic [CHAN_CFG_WIDTH-1:0] channel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= TAP_COUNT_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TAP_COUNT:     tap_count_ff     <= csr_wdata;
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CHAN_CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Effective tap count, half length and channel count after clamping.
   logic [TAP_CW-1:0] taps;
   logic [TAP_CW-1:0] half;
   logic [CH_CW-1:0]  chans;

   always_comb begin
      if (tap_count_ff < MIN_TAPS) begin
         taps = TAP_CW'(MIN_TAPS);
      end else if (tap_count_ff > TAP_CFG_WIDTH'(MAX_TAPS)) begin
         taps = TAP_CW'(MAX_TAPS);
      end else begin
         taps = TAP_CW'(tap_count_ff);
      end
      half = taps >> 1;
      if (channel_count_ff == '0) begin
         chans = CH_CW'(1);
      end else if (channel_count_ff > CHAN_CFG_WIDTH'(MAX_CHANNELS)) begin
         chans = CH_CW'(MAX_CHANNELS);
      end else begin
         chans = CH_CW'(channel_count_ff);
      end
   end

   // Sequencer and datapath registers.
   state_type                      state_ff, state_in;
   logic [HIST_AW-1:0]             clr_addr_ff, clr_addr_in;
   logic [TAP_AW-1:0]              wpos_ff, wpos_in;
   logic [TAP_AW-1:0]              frames_ff, frames_in;
   logic [TAP_AW-1:0]              pos_ff, pos_in;
   logic [CHAN_WIDTH-1:0]          chan_ff, chan_in;
   logic signed [SAMPLE_WIDTH-1:0] low_ff, low_in;
   logic signed [SAMPLE_WIDTH-1:0] high_ff, high_in;
   logic [HIST_AW-1:0]             base_ff, base_in;
   logic [HIST_AW-1:0]             dly_addr_ff, dly_addr_in;
   logic [TAP_AW-1:0]              k_ff, k_in;
   logic [TAP_AW-1:0]              slot_ff, slot_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic signed [LP_WIDTH-1:0]     lp_ff, lp_in;
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [CHAN_WIDTH-1:0]          rsp_chan_ff, rsp_chan_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;

   // Memory read data registers.
   logic signed [COEF_WIDTH-1:0]   coef_rd_ff;
   logic signed [DIFF_WIDTH-1:0]   diff_rd_ff;
   logic signed [SAMPLE_WIDTH-1:0] high_rd_ff;

   // History write port, shared by the clearing pass and sample storage.
   logic                           hist_we;
   logic [HIST_AW-1:0]             hist_waddr;
   logic signed [DIFF_WIDTH-1:0]   hist_wdiff;
   logic signed [SAMPLE_WIDTH-1:0] hist_whigh;
   logic [HIST_AW-1:0]             diff_raddr;

   logic                           accept;
   logic                           coef_we;
   logic [HIST_AW-1:0]             base_calc;
   logic [TAP_CW:0]                dly_sum;
   logic [TAP_AW-1:0]              dly_pos;
   logic signed [ACC_WIDTH-1:0]    acc_rnd;
   logic signed [SUM_WIDTH-1:0]    sum;

   mac_ctrl_type                   mac_ctrl;
   logic signed [ACC_WIDTH-1:0]    mac_acc;
   logic                           mac_busy;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign coef_we    = accept && (in_func == FUNC_LOAD) &&
                       (in_tap_index < TAP_CFG_WIDTH'(MAX_TAPS));

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      wpos_in       = wpos_ff;
      frames_in     = frames_ff;
      pos_in        = pos_ff;
      chan_in       = chan_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      base_in       = base_ff;
      dly_addr_in   = dly_addr_ff;
      k_in          = k_ff;
      slot_in       = slot_ff;
      rd_vld_in     = 1'b0;
      lp_in         = lp_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_chan_in   = rsp_chan_ff;
      rsp_sample_in = rsp_sample_ff;
      hist_we       = 1'b0;
      hist_waddr    = clr_addr_ff;
      hist_wdiff    = '0;
      hist_whigh    = '0;
      mac_ctrl      = '0;

      // Channel base address and the slot of the delayed high sample.
      base_calc = HIST_AW'(chan_ff) * HIST_AW'(MAX_TAPS);
      dly_sum   = (TAP_CW + 1)'(pos_ff) + (TAP_CW + 1)'(taps) - (TAP_CW + 1)'(half);
      if (dly_sum >= (TAP_CW + 1)'(taps)) begin
         dly_pos = TAP_AW'(dly_sum - (TAP_CW + 1)'(taps));
      end else begin
         dly_pos = TAP_AW'(dly_sum);
      end

      acc_rnd = mac_acc + ROUND_HALF;
      sum     = SUM_WIDTH'(lp_ff) + SUM_WIDTH'(high_rd_ff);

      case (state_ff)
         ST_CLEAR: begin
            // Zero both histories one entry per cycle after reset.
            hist_we     = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == HIST_AW'(HIST_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (in_func == FUNC_PROCESS) &&
                ((CH_CW + CHAN_WIDTH)'(in_chan_index) < (CH_CW + CHAN_WIDTH)'(chans))) begin
               chan_in  = in_chan_index;
               low_in   = in_low_sample;
               high_in  = in_high_sample;
               // A position left beyond a shrunken tap count restarts at zero for good.
               if (TAP_CW'(wpos_ff) >= taps) begin
                  pos_in  = '0;
                  wpos_in = '0;
               end else begin
                  pos_in = wpos_ff;
               end
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            hist_we     = 1'b1;
            hist_waddr  = base_calc + HIST_AW'(pos_ff);
            hist_wdiff  = DIFF_WIDTH'(low_ff) - DIFF_WIDTH'(high_ff);
            hist_whigh  = high_ff;
            base_in     = base_calc;
            dly_addr_in = base_calc + HIST_AW'(dly_pos);
            k_in        = '0;
            slot_in     = pos_ff;
            mac_ctrl.clear = 1'b1;
            // The last channel of a frame advances the write position.
            if ((CH_CW + CHAN_WIDTH)'(chan_ff) == (CH_CW + CHAN_WIDTH)'(chans - 1'b1)) begin
               if (TAP_CW'(pos_ff) == taps - 1'b1) begin
                  wpos_in = '0;
               end else begin
                  wpos_in = pos_ff + 1'b1;
               end
               if (TAP_CW'(frames_ff) < half) begin
                  frames_in = frames_ff + 1'b1;
               end
            end
            if (TAP_CW'(frames_ff) >= half) begin
               state_in = ST_MAC;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MAC: begin
            // Issue one coefficient and one history read per cycle.
            rd_vld_in = 1'b1;
            k_in      = k_ff + 1'b1;
            if (slot_ff == '0) begin
               slot_in = TAP_AW'(taps - 1'b1);
            end else begin
               slot_in = slot_ff - 1'b1;
            end
            if (TAP_CW'(k_ff) == taps - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mac_busy) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // Round half up and drop the extra coefficient fraction bits.
            lp_in    = LP_WIDTH'(acc_rnd >>> FRAC_SHIFT);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_chan_in   = chan_ff;
               if (sum > SAT_HI) begin
                  rsp_sample_in = SAMPLE_WIDTH'(SAT_HI);
               end else if (sum < SAT_LO) begin
                  rsp_sample_in = SAMPLE_WIDTH'(SAT_LO);
               end else begin
                  rsp_sample_in = SAMPLE_WIDTH'(sum);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      mac_ctrl.valid = rd_vld_ff;
   end

   assign diff_raddr = base_ff + HIST_AW'(slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         wpos_ff       <= '0;
         frames_ff     <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         wpos_ff       <= wpos_in;
         frames_ff     <= frames_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      pos_ff        <= pos_in;
      chan_ff       <= chan_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      base_ff       <= base_in;
      dly_addr_ff   <= dly_addr_in;
      k_ff          <= k_in;
      slot_ff       <= slot_in;
      lp_ff         <= lp_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // Coefficient memory: contents are undefined until loaded.
   logic signed [COEF_WIDTH-1:0] coef_mem [MAX_TAPS];

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[in_tap_index[TAP_AW-1:0]] <= in_tap_value;
      end
      coef_rd_ff <= coef_mem[k_ff];
   end

   // Difference and high histories, one region of MAX_TAPS entries per channel.
   logic signed [DIFF_WIDTH-1:0]   diff_mem [HIST_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] high_mem [HIST_DEPTH];

   always_ff @(posedge clock) begin
      if (hist_we) begin
         diff_mem[hist_waddr] <= hist_wdiff;
         high_mem[hist_waddr] <= hist_whigh;
      end
      diff_rd_ff <= diff_mem[diff_raddr];
      high_rd_ff <= high_mem[dly_addr_ff];
   end

   ccf_mac #(
      .ACC_WIDTH(ACC_WIDTH)
   ) u_mac (
      .clock(clock),
      .reset(reset),
      .ctrl (mac_ctrl),
      .coef (coef_rd_ff),
      .diff (diff_rd_ff),
      .acc  (mac_acc),
      .busy (mac_busy)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b0, rsp_sample_ff, rsp_chan_ff};

endmodule

### verif/complementary_crossover_fir_unit_tb.sv
// Self-checking testbench for complementary_crossover_fir_unit: coefficient loads,
// warm-up, channel handling, tap and channel clamping and random traffic under idling.
// Depends on ccf_pkg and the unit's RTL; it keeps its own prediction of each result.
`timescale 1ns / 100ps

module complementary_crossover_fir_unit_tb
   import ccf_pkg::*;
();

   localparam int MAX_TAPS     = 513;
   localparam int MAX_CHANNELS = 8;

   // Long enough for a producing pair of the widest filter, with margin.
   localparam int SETTLE_CYCLES = 530;
   // The longest quiet stretch of a correct run is the clearing pass after reset
   // (MAX_TAPS * MAX_CHANNELS = 4104 entries); the hold-off, the pause before a register
   // write and one full-length pair under stalls are all shorter. Several times that.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 1500;

   localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;
   localparam longint OUT_MAX    = 64'sd8388607;
   localparam longint OUT_MIN    = -64'sd8388608;
   localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_SHIFT - 1);

   // One combined sample as it leaves the unit, channel in the low bits.
   typedef struct packed {
      logic signed [23:0] sample;
      logic [2:0]         chan;
   } combined_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         csr_we     = 1'b0;
   logic         csr_addr   = CSR_TAP_COUNT;
   logic [9:0]   csr_wdata  = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // tdata, low bit up: tap_index, tap_value, chan_index, low_sample, high_sample, pad.
   logic [87:0]  req_tdata  = '0;
   // tuser: func.
   logic         req_tuser  = FUNC_LOAD;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // tdata, low bit up: out_chan, out_sample, pad.
   logic [31:0]  rsp_tdata;

   complementary_crossover_fir_unit #(
      .MAX_TAPS     (MAX_TAPS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Shadow state of the unit. Histories start at zero like the unit after its
   // clearing pass; coef_loaded tracks which coefficients were ever written so that
   // no producing pair ever reads an undefined entry.
   // ---------------------------------------------------------------------------------
   bit signed [23:0] coef_mem    [MAX_TAPS];
   bit               coef_loaded [MAX_TAPS];
   bit signed [24:0] diff_hist   [MAX_CHANNELS][MAX_TAPS];
   bit signed [23:0] high_hist   [MAX_CHANNELS][MAX_TAPS];
   int unsigned      wr_pos      = 0;
   int unsigned      frames_seen = 0;
   logic [9:0]       tap_cfg     = TAP_COUNT_RESET;
   logic [3:0]       chan_cfg    = CHANNEL_COUNT_RESET;

   // Combined samples still owed by the unit, oldest first.
   combined_type combined_q [$];

   int mismatch_count = 0;
   int send_gap_pct   = 0;
   int rsp_stall_pct  = 0;
   logic hold_pending = 1'b0;
   logic hold_off     = 1'b0;
   int idle_cycles    = 0;

   function automatic int unsigned active_taps();
      int unsigned t;
      t = tap_cfg;
      if (t < MIN_TAPS) t = MIN_TAPS;
      if (t > MAX_TAPS) t = MAX_TAPS;
      return t;
   endfunction

   function automatic int unsigned active_channels();
      int unsigned c;
      c = chan_cfg;
      if (c < 1) c = 1;
      if (c > MAX_CHANNELS) c = MAX_CHANNELS;
      return c;
   endfunction

   // Applies one accepted transaction to the shadow state and queues the combined
   // sample it must produce, if any.
   task automatic predict_combined(input logic func, input logic [87:0] data);
      int unsigned taps, half, chans, chan, pos, slot, delayed;
      longint acc, total;
      logic signed [23:0] lo, hi;
      combined_type res;
      taps  = active_taps();
      half  = taps / 2;
      chans = active_channels();
      if (func == FUNC_LOAD) begin
         if (data[9:0] < MAX_TAPS) begin
            coef_mem[data[9:0]]    = data[33:10];
            coef_loaded[data[9:0]] = 1'b1;
         end
         return;
      end
      chan = data[36:34];
      if (chan >= chans) return;
      // A shrunken filter can leave the write position past its end.
      if (wr_pos >= taps) wr_pos = 0;
      pos = wr_pos;
      lo  = data[60:37];
      hi  = data[84:61];
      diff_hist[chan][pos] = lo - hi;
      high_hist[chan][pos] = hi;
      if (frames_seen >= half) begin
         acc  = 0;
         slot = pos;
         for (int unsigned k = 0; k < taps; k++) begin
            acc += longint'(coef_mem[k]) * longint'(diff_hist[chan][slot]);
            slot = (slot == 0) ? taps - 1 : slot - 1;
         end
         delayed = (pos + taps - half) % taps;
         // Round half up from the Q2.22 coefficient scale back to Q1.23 samples, then saturate.
         total = longint'(high_hist[chan][delayed]) + ((acc + ROUND_HALF) >>> FRAC_SHIFT);
         if (total > OUT_MAX) total = OUT_MAX;
         if (total < OUT_MIN) total = OUT_MIN;
         res.chan   = chan[2:0];
         res.sample = total[23:0];
         combined_q.push_back(res);
      end
      if (chan == chans - 1) begin
         wr_pos = (pos + 1) % taps;
         if (frames_seen < half) frames_seen++;
      end
   endtask

   function automatic logic signed [23:0] random_sample();
      case ($urandom_range(7))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2, 3:    return 24'($urandom_range(8191)) - 24'd4096;
         default: return 24'($urandom);
      endcase
   endfunction

   // Mostly modest coefficients so that outputs do not all saturate.
   function automatic logic signed [23:0] random_coef();
      logic signed [23:0] r;
      r = 24'($urandom);
      case ($urandom_range(9))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         default: return r >>> $urandom_range(4, 16);
      endcase
   endfunction

   // Fields that the item's function does not use still carry random bits.
   function automatic logic [87:0] pack_load(input logic [9:0] idx, input logic [23:0] value);
      return {3'b000, 24'($urandom), 24'($urandom), 3'($urandom), value, idx};
   endfunction

   function automatic logic [87:0] pack_pair(input logic [2:0] chan,
                                             input logic [23:0] lo, input logic [23:0] hi);
      return {3'b000, hi, lo, chan, 24'($urandom), 10'($urandom)};
   endfunction

   function automatic void log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
   endfunction

   // Offers one transaction, optionally after an idle gap, and waits for acceptance.
   // The valid is left high so that a following transaction continues without a bubble.
   task automatic send_item(input logic func, input logic [87:0] data);
      if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_combined(func, data);
   endtask

   // Sends a sample pair. If it is going to produce, any coefficient in use that was
   // never written is loaded first.
   task automatic send_pair(input logic [2:0] chan, input logic [23:0] lo,
                            input logic [23:0] hi);
      if (chan < active_channels() && frames_seen >= active_taps() / 2) begin
         for (int unsigned k = 0; k < active_taps(); k++) begin
            if (!coef_loaded[k]) send_item(FUNC_LOAD, pack_load(k[9:0], random_coef()));
         end
      end
      send_item(FUNC_PROCESS, pack_pair(chan, lo, hi));
   endtask

   // Registers change only with the unit idle: every owed result has come back and
   // the unit has had time to finish any pair that produces nothing.
   task automatic set_config(input logic [9:0] taps, input logic [3:0] chans);
      req_tvalid <= 1'b0;
      while (combined_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_TAP_COUNT;
      csr_wdata <= taps;
      @(posedge clock);
      csr_addr  <= CSR_CHANNEL_COUNT;
      csr_wdata <= {6'd0, chans};
      @(posedge clock);
      csr_we    <= 1'b0;
      tap_cfg  = taps;
      chan_cfg = chans;
   endtask

   // ---------------------------------------------------------------------------------
   // Directed tests.
   // ---------------------------------------------------------------------------------

   // Coefficient extremes at both ends of the store, plus indexes past the store,
   // which the unit must drop without touching anything.
   task automatic test_coefficient_edges();
      send_item(FUNC_LOAD, pack_load(10'd0, SAMPLE_MIN));
      send_item(FUNC_LOAD, pack_load(10'd512, SAMPLE_MAX));
      send_item(FUNC_LOAD, pack_load(10'd513, SAMPLE_MAX));
      send_item(FUNC_LOAD, pack_load(10'd1023, SAMPLE_MIN));
   endtask

   // With the reset setting of one channel, pairs for higher channels are ignored.
   // The channel-zero pairs with extreme samples are still in warm-up.
   task automatic test_ignored_channels();
      send_pair(3'd7, SAMPLE_MAX, SAMPLE_MIN);
      send_pair(3'd1, SAMPLE_MIN, SAMPLE_MAX);
      send_pair(3'd0, SAMPLE_MAX, SAMPLE_MIN);
      send_pair(3'd0, SAMPLE_MIN, SAMPLE_MAX);
      send_pair(3'd0, 24'd0, 24'd0);
   endtask

   // Zero in both registers is clamped to 33 taps and one channel. Pairs run up to the
   // end of warm-up, so the first result appears exactly when half the taps' frames are
   // in, followed by the widest possible differences.
   task automatic test_warmup_boundary();
      set_config(10'd0, 4'd0);
      while (frames_seen < active_taps() / 2) begin
         send_pair(3'd0, random_sample(), random_sample());
      end
      send_pair(3'd0, SAMPLE_MAX, SAMPLE_MIN);
      send_pair(3'd0, SAMPLE_MIN, SAMPLE_MAX);
      send_pair(3'd0, SAMPLE_MAX, SAMPLE_MAX);
      send_pair(3'd0, SAMPLE_MIN, SAMPLE_MIN);
   endtask

   // Moves the write position near the end of a 47-tap filter, then shrinks the filter
   // so that the position lies past its end and must restart at zero.
   task automatic test_tap_shrink();
      set_config(10'd47, 4'd1);
      while (wr_pos < 40) send_pair(3'd0, random_sample(), random_sample());
      set_config(10'd35, 4'd1);
      repeat (6) send_pair(3'd0, random_sample(), random_sample());
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering, so
   // the unit fills up and has to stall its input.
   task automatic test_input_backpressure();
      int unsigned chan;
      chan = 0;
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      hold_pending <= 1'b1;
      repeat (30) begin
         send_pair(chan[2:0], random_sample(), random_sample());
         chan = (chan + 1) % active_channels();
      end
   endtask

   // Mostly in-order frames with random content; the rest are coefficient loads
   // (some past the store) and pairs on arbitrary channels, possibly ignored.
   task automatic run_traffic(input int n_items, input int gap_pct, input int stall_pct);
      int unsigned next_chan, choice;
      next_chan     = 0;
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      repeat (n_items) begin
         choice = $urandom_range(99);
         if (choice < 8) begin
            send_item(FUNC_LOAD, pack_load(10'($urandom_range(1023)), random_coef()));
         end else if (choice < 13) begin
            send_pair(3'($urandom_range(7)), random_sample(), random_sample());
         end else begin
            send_pair(next_chan[2:0], random_sample(), random_sample());
            next_chan = (next_chan + 1) % active_channels();
         end
      end
   endtask

   // Random traffic across settings that include an even tap count, an over-range
   // channel count and the widest filter, under each idling mode. The widest filter
   // needs a long warm-up and a full coefficient store before its first results.
   task automatic test_random_traffic();
      set_config(10'd34, 4'd4);
      run_traffic(24, 0, 0);
      set_config(10'd33, 4'd15);
      run_traffic(24, 56, 0);
      set_config(10'd41, 4'd8);
      run_traffic(24, 0, 56);
      set_config(10'd1023, 4'd1);
      run_traffic(290, 19, 19);
      set_config(10'd65, 4'd2);
      test_input_backpressure();
      run_traffic(16, 0, 0);
      set_config(10'd33, 4'd8);
      run_traffic(16, 0, 56);
   endtask

   // ---------------------------------------------------------------------------------
   // Result side: random stalls plus the long hold-off, and the scoreboard check.
   // ---------------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending <= 1'b0;
            hold_off     <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off <= 1'b0;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off)
            rsp_tready <= 1'b0;
         else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct)
            rsp_tready <= 1'b0;
         else
            rsp_tready <= 1'b1;
      end
   end

   // Each result transaction is matched field by field against the oldest prediction.
   always @(posedge clock) begin
      combined_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[26:0];
         if (combined_q.size() == 0) begin
            log_mismatch($sformatf("unexpected result chan %0d sample %0d",
                                   got.chan, got.sample));
         end else begin
            want = combined_q.pop_front();
            if (got.chan !== want.chan)
               log_mismatch($sformatf("out_chan expected %0d got %0d", want.chan, got.chan));
            if (got.sample !== want.sample)
               log_mismatch($sformatf("out_sample chan %0d expected %0d got %0d",
                                      want.chan, want.sample, got.sample));
         end
      end
   end

   // The run is aborted if neither side moves a transaction for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Test sequence. The first transactions simply wait out the clearing pass, since
   // the unit keeps req_tready low until its histories are zeroed.
   // ---------------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_coefficient_edges();
      test_ignored_channels();
      test_warmup_boundary();
      test_tap_shrink();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (combined_q.size() != 0) @(posedge clock);
      // Late or extra results still show up as failures during this tail.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && combined_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
rtl/ccf_pkg.sv
rtl/ccf_mac.sv
rtl/complementary_crossover_fir_unit.sv
verif/complementary_crossover_fir_unit_tb.sv
